[rtl/wtps_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the task scheduler.
`default_nettype none
package wtps_pkg;

  localparam int TASK_SLOTS_DEF  = 16;
  localparam int EVENT_DEPTH_DEF = 8;
  localparam int EVENT_WIDTH_DEF = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int TQ_W       = 10;
  localparam int SLICE_W    = 16;
  localparam int ID_W       = 16;
  localparam int PRIO_W     = 4;
  localparam int TIME_W     = 32;
  localparam int MODE_W     = 3;
  localparam int OUTC_W     = 3;

  localparam logic [TQ_W-1:0]    TQ_RESET = 10'd10;
  localparam logic [SLICE_W-1:0] BS_RESET = 16'd1000;
  localparam logic [SLICE_W-1:0] PS_RESET = 16'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_TICK_QUANTUM   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SLICE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY_SLICE = 2'd2;

  localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_START  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_KILL   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_QUEUE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PULL   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ENABLE = 3'd5;

  localparam logic [OUTC_W-1:0] OUT_OK          = 3'd0;
  localparam logic [OUTC_W-1:0] OUT_NOT_FOUND   = 3'd1;
  localparam logic [OUTC_W-1:0] OUT_TABLE_FULL  = 3'd2;
  localparam logic [OUTC_W-1:0] OUT_QUEUE_FULL  = 3'd3;
  localparam logic [OUTC_W-1:0] OUT_NOT_ENABLED = 3'd4;
  localparam logic [OUTC_W-1:0] OUT_WAITING     = 3'd5;

  localparam logic [1:0] ST_DEAD  = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_SUSP  = 2'd2;
  localparam logic [1:0] ST_RUN   = 2'd3;

  typedef struct packed {
    logic latch;
    logic idx_clr;
    logic tick_step;
    logic pick_step;
    logic free_step;
    logic find_step;
    logic sel_run;
    logic set_dis;
    logic div_start;
    logic pick_apply;
    logic act;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic enabled;
    logic tgt_zero;
    logic last;
    logic run_valid;
    logic div_done;
    logic over_quota;
    logic act_pick;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

[rtl/wait_time_priority_task_scheduler_core.sv]
// Top level of the wait-time priority task scheduler.
// Each request produces exactly one result. The controller walks the task table one slot per
// cycle. An enabled tick makes one walk to age tasks; when a task is running it then divides
// base_slice by the live task count, and it makes a second walk to choose a task when no task
// runs or the running one has used its quota. Start and queue by id make one walk. Kill by id
// makes one walk, or two when it removes the running task while enabled. Requests aimed at the
// running task, and enable, make no walk unless they reschedule, and then one walk to choose.
// A result that is not taken holds the controller, once the next result is ready, until it is.
// A new request is taken while the previous result waits.
`default_nettype none
module wait_time_priority_task_scheduler_core
  import wtps_pkg::*;
#(
  parameter int TASK_SLOTS  = TASK_SLOTS_DEF,
  parameter int EVENT_DEPTH = EVENT_DEPTH_DEF,
  parameter int EVENT_WIDTH = EVENT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [MODE_W-1:0]      in_mode,
  input  wire logic [ID_W-1:0]        in_target_id,
  input  wire logic [PRIO_W-1:0]      in_new_priority,
  input  wire logic [EVENT_WIDTH-1:0] in_event_word,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [ID_W-1:0]        out_running_id,
  output logic                        out_switched,
  output logic      [OUTC_W-1:0]      out_outcome,
  output logic      [ID_W-1:0]        out_new_id,
  output logic                        out_event_valid,
  output logic      [EVENT_WIDTH-1:0] out_event_out,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  wtps_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  wtps_dp #(
    .TASK_SLOTS (TASK_SLOTS),
    .EVENT_DEPTH(EVENT_DEPTH),
    .EVENT_WIDTH(EVENT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_mode        (in_mode),
    .in_target_id   (in_target_id),
    .in_new_priority(in_new_priority),
    .in_event_word  (in_event_word),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_running_id (out_running_id),
    .out_switched   (out_switched),
    .out_outcome    (out_outcome),
    .out_new_id     (out_new_id),
    .out_event_valid(out_event_valid),
    .out_event_out  (out_event_out),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

endmodule
`default_nettype wire

[rtl/wtps_div.sv]
// Restoring divider producing one quotient bit per cycle.
`default_nettype none
module wtps_div #(
  parameter int NW = 16,
  parameter int DW = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [NW-1:0] quot,
  output logic               done
);
  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem_r;
  logic [NW-1:0]    quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DW:0]      trial;
  logic             fits;

  assign trial = {rem_r, quo_r[NW-1]};
  assign fits  = trial >= {1'b0, den};
  assign quot  = quo_r;
  assign done  = !busy_r && !start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= fits ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
      quo_r <= {quo_r[NW-2:0], fits};
    end
  end

endmodule
`default_nettype wire

[rtl/wtps_dp.sv]
// Datapath: task table, event store, configuration registers, divider and result register.
`default_nettype none
module wtps_dp
  import wtps_pkg::*;
#(
  parameter int TASK_SLOTS  = TASK_SLOTS_DEF,
  parameter int EVENT_DEPTH = EVENT_DEPTH_DEF,
  parameter int EVENT_WIDTH = EVENT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cmd_t                   cmd,
  output sts_t                        sts,
  input  wire logic [MODE_W-1:0]      in_mode,
  input  wire logic [ID_W-1:0]        in_target_id,
  input  wire logic [PRIO_W-1:0]      in_new_priority,
  input  wire logic [EVENT_WIDTH-1:0] in_event_word,
  input  wire logic                   out_ready,
  output logic                        out_valid,
  output logic      [ID_W-1:0]        out_running_id,
  output logic                        out_switched,
  output logic      [OUTC_W-1:0]      out_outcome,
  output logic      [ID_W-1:0]        out_new_id,
  output logic                        out_event_valid,
  output logic      [EVENT_WIDTH-1:0] out_event_out,
  input  wire logic                   cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);
  localparam int SW  = $clog2(TASK_SLOTS);
  localparam int CW  = $clog2(TASK_SLOTS + 1);
  localparam int HW  = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int ECW = $clog2(EVENT_DEPTH + 1);
  localparam int AW  = $clog2(TASK_SLOTS * EVENT_DEPTH);
  localparam int SCW = TIME_W + PRIO_W + 1;
  localparam int QW  = SLICE_W + PRIO_W + 1;

  logic [1:0]        status_r  [TASK_SLOTS];
  logic              started_r [TASK_SLOTS];
  logic [ID_W-1:0]   id_r      [TASK_SLOTS];
  logic [PRIO_W-1:0] prio_r    [TASK_SLOTS];
  logic [TIME_W-1:0] wt_r      [TASK_SLOTS];
  logic [TIME_W-1:0] rt_r      [TASK_SLOTS];
  logic [ECW-1:0]    ecnt_r    [TASK_SLOTS];
  logic [HW-1:0]     head_r    [TASK_SLOTS];
  logic [EVENT_WIDTH-1:0] mem [TASK_SLOTS * EVENT_DEPTH];

  logic [TQ_W-1:0]    tq_r;
  logic [SLICE_W-1:0] bs_r, ps_r;

  logic [MODE_W-1:0]      mode_r;
  logic [ID_W-1:0]        target_r;
  logic [PRIO_W-1:0]      nprio_r;
  logic [EVENT_WIDTH-1:0] word_r;
  logic                   before_valid_r;
  logic [SW-1:0]          before_slot_r;
  logic [SW-1:0]          idx_r;
  logic                   found_r;
  logic [SW-1:0]          fslot_r;
  logic                   plock_r, pfound_r;
  logic [SW-1:0]          pslot_r;
  logic [ID_W-1:0]        pid_r;
  logic [SCW-1:0]         best_r;
  logic [CW-1:0]          live_r;
  logic [TIME_W-1:0]      run_rt_r;
  logic [PRIO_W-1:0]      run_prio_r;
  logic                   run_valid_r;
  logic [SW-1:0]          run_slot_r;
  logic [ID_W-1:0]        run_id_r;
  logic                   enabled_r;
  logic [ID_W-1:0]        next_id_r;
  logic [OUTC_W-1:0]      outcome_r;
  logic [ID_W-1:0]        new_id_r;
  logic                   ev_valid_r;
  logic [EVENT_WIDTH-1:0] rd_r;
  logic                   out_valid_r;

  logic [1:0]        cur_st;
  logic [PRIO_W-1:0] cur_prio;
  logic [TIME_W-1:0] cur_wt, cur_rt, wt_add, rt_add;
  logic [TIME_W:0]   wt_sum, rt_sum;
  logic [ECW-1:0]    cur_ec, f_ec;
  logic [HW-1:0]     cur_head, f_head;
  logic [SCW-1:0]    score;
  logic              step;
  logic              tgt_ok, queue_ok, pull_pop, run_killed;
  logic [ID_W-1:0]   nid;
  logic [ECW:0]      wsum;
  logic [HW-1:0]     woff, off;
  logic [AW-1:0]     addr;
  logic              mem_we, mem_re;
  logic [SLICE_W-1:0] quot;
  logic              div_done;
  logic [QW-1:0]     quota;

  assign cur_st   = status_r[idx_r];
  assign cur_prio = prio_r[idx_r];
  assign cur_wt   = wt_r[idx_r];
  assign cur_rt   = rt_r[idx_r];
  assign cur_ec   = ecnt_r[idx_r];
  assign cur_head = head_r[idx_r];
  assign f_ec     = ecnt_r[fslot_r];
  assign f_head   = head_r[fslot_r];

  assign wt_sum = {1'b0, cur_wt} + (TIME_W + 1)'(tq_r);
  assign rt_sum = {1'b0, cur_rt} + (TIME_W + 1)'(tq_r);
  assign wt_add = wt_sum[TIME_W] ? '1 : wt_sum[TIME_W-1:0];
  assign rt_add = rt_sum[TIME_W] ? '1 : rt_sum[TIME_W-1:0];
  assign score  = SCW'(cur_wt) * SCW'({1'b0, cur_prio} + 5'd1);

  assign step = cmd.tick_step | cmd.pick_step | cmd.free_step | cmd.find_step;

  assign tgt_ok     = found_r && (fslot_r != '0);
  assign queue_ok   = tgt_ok && (f_ec != ECW'(EVENT_DEPTH));
  assign pull_pop   = found_r && (f_ec != '0);
  assign run_killed = tgt_ok && run_valid_r && (run_slot_r == fslot_r);
  assign nid        = (next_id_r == '1) ? ID_W'(1) : next_id_r + 1'b1;

  assign wsum = (ECW + 1)'(f_head) + (ECW + 1)'(f_ec);
  assign woff = (wsum >= (ECW + 1)'(EVENT_DEPTH)) ? HW'(wsum - (ECW + 1)'(EVENT_DEPTH))
                                                  : HW'(wsum);
  assign off  = (mode_r == MODE_QUEUE) ? woff : f_head;
  assign addr = AW'(fslot_r) * AW'(EVENT_DEPTH) + AW'(off);
  assign mem_we = cmd.act && (mode_r == MODE_QUEUE) && queue_ok;
  assign mem_re = cmd.act && (mode_r == MODE_PULL) && pull_pop;

  assign quota = QW'(quot) + QW'(run_prio_r) * QW'(ps_r);

  wtps_div #(
    .NW(SLICE_W),
    .DW(CW)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .num  (bs_r),
    .den  (live_r),
    .quot (quot),
    .done (div_done)
  );

  always_comb begin
    sts.mode       = mode_r;
    sts.enabled    = enabled_r;
    sts.tgt_zero   = target_r == '0;
    sts.last       = idx_r == SW'(TASK_SLOTS - 1);
    sts.run_valid  = run_valid_r;
    sts.div_done   = div_done;
    sts.over_quota = run_rt_r > TIME_W'(quota);
    sts.out_free   = !out_valid_r || out_ready;
    unique case (mode_r)
      MODE_KILL:   sts.act_pick = run_killed && enabled_r;
      MODE_PULL:   sts.act_pick = found_r && !pull_pop && enabled_r;
      MODE_ENABLE: sts.act_pick = !enabled_r;
      default:     sts.act_pick = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tq_r <= TQ_RESET;
      bs_r <= BS_RESET;
      ps_r <= PS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TICK_QUANTUM:   tq_r <= cfg_data[TQ_W-1:0];
        CFG_BASE_SLICE:     bs_r <= cfg_data;
        CFG_PRIORITY_SLICE: ps_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        status_r[i]  <= ST_DEAD;
        started_r[i] <= 1'b0;
        id_r[i]      <= '0;
        ecnt_r[i]    <= '0;
        head_r[i]    <= '0;
      end
      status_r[0]  <= ST_SUSP;
      started_r[0] <= 1'b1;
    end else begin
      if (cmd.tick_step && cur_st == ST_SUSP && cur_ec != '0) begin
        status_r[idx_r] <= ST_READY;
        ecnt_r[idx_r]   <= cur_ec - 1'b1;
        head_r[idx_r]   <= (cur_head == HW'(EVENT_DEPTH - 1)) ? '0 : cur_head + 1'b1;
      end
      if (cmd.pick_apply && pfound_r) begin
        if (run_valid_r) begin
          status_r[run_slot_r] <= ST_READY;
        end
        status_r[pslot_r]  <= ST_RUN;
        started_r[pslot_r] <= 1'b1;
      end
      if (cmd.act) begin
        unique case (mode_r)
          MODE_START: if (found_r) begin
            status_r[fslot_r]  <= ST_READY;
            started_r[fslot_r] <= 1'b0;
            id_r[fslot_r]      <= nid;
            ecnt_r[fslot_r]    <= '0;
            head_r[fslot_r]    <= '0;
          end
          MODE_KILL: if (tgt_ok) begin
            status_r[fslot_r] <= ST_DEAD;
            ecnt_r[fslot_r]   <= '0;
            head_r[fslot_r]   <= '0;
          end
          MODE_QUEUE: if (queue_ok) begin
            ecnt_r[fslot_r] <= f_ec + 1'b1;
          end
          MODE_PULL: if (pull_pop) begin
            ecnt_r[fslot_r] <= f_ec - 1'b1;
            head_r[fslot_r] <= (f_head == HW'(EVENT_DEPTH - 1)) ? '0 : f_head + 1'b1;
          end else if (found_r) begin
            status_r[fslot_r] <= ST_SUSP;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_step) begin
      if (cur_st == ST_RUN) begin
        rt_r[idx_r] <= rt_add;
      end else if (cur_st != ST_DEAD) begin
        wt_r[idx_r] <= wt_add;
      end
    end
    if (cmd.act && mode_r == MODE_START && found_r) begin
      wt_r[fslot_r]   <= '0;
      rt_r[fslot_r]   <= '0;
      prio_r[fslot_r] <= nprio_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= word_r;
    end
    if (mem_re) begin
      rd_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r         <= in_mode;
      target_r       <= in_target_id;
      nprio_r        <= in_new_priority;
      word_r         <= in_event_word;
      before_valid_r <= run_valid_r;
      before_slot_r  <= run_slot_r;
    end
    if (cmd.tick_step && cur_st == ST_RUN) begin
      run_rt_r   <= rt_add;
      run_prio_r <= cur_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      found_r     <= 1'b0;
      fslot_r     <= '0;
      plock_r     <= 1'b0;
      pfound_r    <= 1'b0;
      pslot_r     <= '0;
      pid_r       <= '0;
      best_r      <= '0;
      live_r      <= '0;
      run_valid_r <= 1'b0;
      run_slot_r  <= '0;
      run_id_r    <= '0;
      enabled_r   <= 1'b0;
      next_id_r   <= '0;
      outcome_r   <= OUT_OK;
      new_id_r    <= '0;
      ev_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.idx_clr) begin
        idx_r    <= '0;
        found_r  <= 1'b0;
        plock_r  <= 1'b0;
        pfound_r <= 1'b0;
        best_r   <= '0;
        live_r   <= '0;
      end else if (step) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.tick_step && cur_st != ST_DEAD) begin
        live_r <= live_r + 1'b1;
      end
      if (cmd.free_step && !found_r && cur_st == ST_DEAD) begin
        found_r <= 1'b1;
        fslot_r <= idx_r;
      end
      if (cmd.find_step && !found_r && cur_st != ST_DEAD && id_r[idx_r] == target_r) begin
        found_r <= 1'b1;
        fslot_r <= idx_r;
      end
      if (cmd.sel_run) begin
        found_r <= run_valid_r;
        fslot_r <= run_slot_r;
      end
      if (cmd.pick_step && !plock_r && cur_st == ST_READY) begin
        if (!started_r[idx_r]) begin
          plock_r  <= 1'b1;
          pfound_r <= 1'b1;
          pslot_r  <= idx_r;
          pid_r    <= id_r[idx_r];
        end else if (score > best_r) begin
          best_r   <= score;
          pfound_r <= 1'b1;
          pslot_r  <= idx_r;
          pid_r    <= id_r[idx_r];
        end
      end
      if (cmd.pick_apply && pfound_r) begin
        run_valid_r <= 1'b1;
        run_slot_r  <= pslot_r;
        run_id_r    <= pid_r;
      end
      if (cmd.latch) begin
        outcome_r  <= OUT_OK;
        new_id_r   <= '0;
        ev_valid_r <= 1'b0;
      end
      if (cmd.set_dis) begin
        outcome_r <= OUT_NOT_ENABLED;
      end
      if (cmd.act) begin
        unique case (mode_r)
          MODE_START: begin
            if (found_r) begin
              next_id_r <= nid;
              new_id_r  <= nid;
            end else begin
              outcome_r <= OUT_TABLE_FULL;
            end
          end
          MODE_KILL: begin
            if (!tgt_ok) begin
              outcome_r <= OUT_NOT_FOUND;
            end else if (run_killed) begin
              run_valid_r <= 1'b0;
            end
          end
          MODE_QUEUE: begin
            if (!tgt_ok) begin
              outcome_r <= OUT_NOT_FOUND;
            end else if (!queue_ok) begin
              outcome_r <= OUT_QUEUE_FULL;
            end
          end
          MODE_PULL: begin
            if (!found_r) begin
              outcome_r <= OUT_NOT_FOUND;
            end else if (pull_pop) begin
              ev_valid_r <= 1'b1;
            end else begin
              outcome_r   <= OUT_WAITING;
              run_valid_r <= 1'b0;
            end
          end
          MODE_ENABLE: begin
            enabled_r <= 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_running_id  <= run_valid_r ? run_id_r : '0;
      out_switched    <= (before_valid_r != run_valid_r) ||
                         (run_valid_r && before_slot_r != run_slot_r);
      out_outcome     <= outcome_r;
      out_new_id      <= new_id_r;
      out_event_valid <= ev_valid_r;
      out_event_out   <= ev_valid_r ? rd_r : '0;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

[rtl/wtps_ctrl.sv]
// Controller state machine sequencing slot walks, division and result hand-off.
`default_nettype none
module wtps_ctrl
  import wtps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_TICK     = 4'd2;
  localparam logic [3:0] S_TICK_END = 4'd3;
  localparam logic [3:0] S_DIV      = 4'd4;
  localparam logic [3:0] S_QCHK     = 4'd5;
  localparam logic [3:0] S_PICK     = 4'd6;
  localparam logic [3:0] S_PAPPLY   = 4'd7;
  localparam logic [3:0] S_FREE     = 4'd8;
  localparam logic [3:0] S_FIND     = 4'd9;
  localparam logic [3:0] S_ACT      = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.mode)
          MODE_TICK: begin
            if (!sts.enabled) begin
              cmd.set_dis = 1'b1;
              state_nxt   = S_DONE;
            end else begin
              cmd.idx_clr = 1'b1;
              state_nxt   = S_TICK;
            end
          end
          MODE_START: begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_FREE;
          end
          MODE_KILL, MODE_QUEUE: begin
            if (sts.tgt_zero) begin
              cmd.sel_run = 1'b1;
              state_nxt   = S_ACT;
            end else begin
              cmd.idx_clr = 1'b1;
              state_nxt   = S_FIND;
            end
          end
          MODE_PULL: begin
            cmd.sel_run = 1'b1;
            state_nxt   = S_ACT;
          end
          MODE_ENABLE: state_nxt = S_ACT;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_TICK: begin
        cmd.tick_step = 1'b1;
        if (sts.last) begin
          state_nxt = S_TICK_END;
        end
      end
      S_TICK_END: begin
        if (!sts.run_valid) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_PICK;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_QCHK;
        end
      end
      S_QCHK: begin
        if (sts.over_quota) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_PICK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PICK: begin
        cmd.pick_step = 1'b1;
        if (sts.last) begin
          state_nxt = S_PAPPLY;
        end
      end
      S_PAPPLY: begin
        cmd.pick_apply = 1'b1;
        state_nxt      = S_DONE;
      end
      S_FREE: begin
        cmd.free_step = 1'b1;
        if (sts.last) begin
          state_nxt = S_ACT;
        end
      end
      S_FIND: begin
        cmd.find_step = 1'b1;
        if (sts.last) begin
          state_nxt = S_ACT;
        end
      end
      S_ACT: begin
        cmd.act = 1'b1;
        if (sts.act_pick) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_PICK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[dv/tb_wait_time_priority_task_scheduler_core.sv]
// Self-checking testbench for the wait-time priority task scheduler core.
`default_nettype none
module tb_wait_time_priority_task_scheduler_core;
  import wtps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;
  localparam int NEV = 8;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [15:0] running_id;
    logic        switched;
    logic [2:0]  outcome;
    logic [15:0] new_id;
    logic        event_valid;
    logic [31:0] event_out;
  } sched_result_t;

  // Golden model of the task table, kept at the block's widths.
  class sched_scoreboard;
    logic [9:0]  quantum;
    logic [15:0] bslice;
    logic [15:0] pslice;
    logic [1:0]  status [NSLOT];
    logic        started [NSLOT];
    logic [15:0] tid [NSLOT];
    logic [3:0]  prio [NSLOT];
    logic [31:0] wait_t [NSLOT];
    logic [31:0] run_t [NSLOT];
    logic [3:0]  ecount [NSLOT];
    logic [2:0]  ehead [NSLOT];
    logic [31:0] estore [NSLOT*NEV];
    logic [15:0] id_counter;
    int          used;
    bit          enabled;
    sched_result_t pending [$];
    int          errors;
    int          checked;

    function new();
      quantum = TQ_RESET;
      bslice = BS_RESET;
      pslice = PS_RESET;
      for (int i = 0; i < NSLOT; i++) begin
        status[i] = ST_DEAD; started[i] = 0; tid[i] = 0; prio[i] = 0;
        wait_t[i] = 0; run_t[i] = 0; ecount[i] = 0; ehead[i] = 0;
      end
      foreach (estore[i]) estore[i] = 0;
      status[0] = ST_SUSP;
      started[0] = 1;
      id_counter = 0;
      used = 1;
      enabled = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      if (idx == CFG_TICK_QUANTUM) quantum = val[9:0];
      else if (idx == CFG_BASE_SLICE) bslice = val;
      else if (idx == CFG_PRIORITY_SLICE) pslice = val;
    endfunction

    function logic [31:0] sat(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFFFFFF : s[31:0];
    endfunction

    function int running_slot();
      for (int i = 0; i < used; i++) if (status[i] == ST_RUN) return i;
      return -1;
    endfunction

    function int slot_of(logic [15:0] id);
      if (id == 0) return running_slot();
      for (int i = 0; i < used; i++) if (status[i] != ST_DEAD && tid[i] == id) return i;
      return -1;
    endfunction

    function logic [31:0] pop(int s);
      logic [31:0] v;
      v = estore[s*NEV + ehead[s]];
      ehead[s] = ehead[s] + 3'd1;
      ecount[s] = ecount[s] - 4'd1;
      return v;
    endfunction

    function int choose();
      logic [36:0] best, sc;
      int sel;
      best = 0;
      sel = -1;
      for (int i = 0; i < used; i++) begin
        if (status[i] != ST_READY) continue;
        if (!started[i]) return i;
        sc = wait_t[i] * ({33'd0, prio[i]} + 37'd1);
        if (sc > best) begin
          best = sc; sel = i;
        end
      end
      return sel;
    endfunction

    function void resched();
      int j;
      j = choose();
      if (j >= 0) begin
        started[j] = 1; status[j] = ST_RUN;
      end else started[0] = 1;
    endfunction

    function void age_tasks();
      int run, cnt, j;
      logic [31:0] quota;
      logic [31:0] dummy;
      run = -1;
      cnt = 0;
      for (int i = 0; i < used; i++) begin
        if (status[i] == ST_RUN) begin
          run_t[i] = sat(run_t[i], {22'd0, quantum}); run = i; cnt++;
        end else if (status[i] != ST_DEAD) begin
          wait_t[i] = sat(wait_t[i], {22'd0, quantum}); cnt++;
        end
        if (status[i] == ST_SUSP && ecount[i] != 0) begin
          dummy = pop(i); status[i] = ST_READY;
        end
      end
      if (run < 0) begin
        resched();
        return;
      end
      quota = 32'(bslice / cnt) + prio[run] * pslice;
      if (run_t[run] > quota) begin
        j = choose();
        if (j >= 0) begin
          status[run] = ST_READY; started[j] = 1; status[j] = ST_RUN;
        end
      end
    endfunction

    function void note_request(logic [2:0] mode, logic [15:0] tgt, logic [3:0] np,
                               logic [31:0] word);
      sched_result_t r;
      int pre, post, s, fs;
      bit was_run;
      r = '0;
      pre = running_slot();
      case (mode)
        MODE_TICK: if (!enabled) r.outcome = OUT_NOT_ENABLED; else age_tasks();
        MODE_START: begin
          fs = -1;
          for (int i = 0; i < used; i++) if (fs < 0 && status[i] == ST_DEAD) fs = i;
          if (fs < 0 && used < NSLOT) begin
            fs = used; used++;
          end
          if (fs < 0) r.outcome = OUT_TABLE_FULL;
          else begin
            id_counter = id_counter + 16'd1;
            if (id_counter == 0) id_counter = 1;
            status[fs] = ST_READY; started[fs] = 0; tid[fs] = id_counter; prio[fs] = np;
            wait_t[fs] = 0; run_t[fs] = 0; ecount[fs] = 0; ehead[fs] = 0;
            r.new_id = id_counter;
          end
        end
        MODE_KILL: begin
          s = slot_of(tgt);
          if (s <= 0) r.outcome = OUT_NOT_FOUND;
          else begin
            was_run = status[s] == ST_RUN;
            status[s] = ST_DEAD; ecount[s] = 0; ehead[s] = 0;
            if (was_run && enabled) resched();
          end
        end
        MODE_QUEUE: begin
          s = slot_of(tgt);
          if (s <= 0) r.outcome = OUT_NOT_FOUND;
          else if (ecount[s] >= NEV) r.outcome = OUT_QUEUE_FULL;
          else begin
            estore[s*NEV + 3'(ehead[s] + ecount[s])] = word;
            ecount[s] = ecount[s] + 4'd1;
          end
        end
        MODE_PULL: begin
          s = running_slot();
          if (s < 0) r.outcome = OUT_NOT_FOUND;
          else if (ecount[s] != 0) begin
            r.event_out = pop(s); r.event_valid = 1;
          end else begin
            status[s] = ST_SUSP; r.outcome = OUT_WAITING;
            if (enabled) resched();
          end
        end
        MODE_ENABLE: if (!enabled) begin
          enabled = 1; resched();
        end
        default: ;
      endcase
      post = running_slot();
      r.running_id = post >= 0 ? tid[post] : 16'd0;
      r.switched = pre != post;
      pending.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] exp);
      errors++;
      if (errors <= 50)
        $display("MISMATCH result %0d %s: got %0h expected %0h", checked, what, got, exp);
    endtask

    task check_result(sched_result_t got);
      sched_result_t exp;
      checked++;
      if (pending.size() == 0) begin
        report("result with no request outstanding", 0, 0);
        return;
      end
      exp = pending.pop_front();
      if (got.running_id != exp.running_id)
        report("running_id", 32'(got.running_id), 32'(exp.running_id));
      if (got.switched != exp.switched)
        report("switched", 32'(got.switched), 32'(exp.switched));
      if (got.outcome != exp.outcome) report("outcome", 32'(got.outcome), 32'(exp.outcome));
      if (got.new_id != exp.new_id) report("new_id", 32'(got.new_id), 32'(exp.new_id));
      if (got.event_valid != exp.event_valid)
        report("event_valid", 32'(got.event_valid), 32'(exp.event_valid));
      if (got.event_out != exp.event_out) report("event_out", got.event_out, exp.event_out);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] in_mode = 0;
  logic [15:0] in_target_id = 0;
  logic [3:0] in_new_priority = 0;
  logic [31:0] in_event_word = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [15:0] out_running_id;
  logic out_switched;
  logic [2:0] out_outcome;
  logic [15:0] out_new_id;
  logic out_event_valid;
  logic [31:0] out_event_out;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;

  sched_scoreboard sb;
  int cycles = 0;
  int sent = 0;
  bit drain_stalls = 1;

  always #5 clk = ~clk;

  wait_time_priority_task_scheduler_core dut (.*);

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_running_id, out_switched, out_outcome, out_new_id,
                       out_event_valid, out_event_out});
  end

  initial begin : sink
    int g;
    forever begin
      @(posedge clk);
      if (drain_stalls) begin
        g = gap_len();
        out_ready <= (g == 0);
      end else out_ready <= 1;
    end
  end

  task automatic send_request(logic [2:0] m, logic [15:0] t, logic [3:0] p, logic [31:0] w);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_mode <= m;
    in_target_id <= t;
    in_new_priority <= p;
    in_event_word <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_request(m, t, p, w);
    sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic live_id(output logic [15:0] id);
    int k;
    k = $urandom_range(1, NSLOT - 1);
    id = (sb.status[k] != ST_DEAD) ? sb.tid[k] : 16'(sb.id_counter + 1);
  endtask

  task automatic random_phase(int n);
    int r;
    logic [15:0] t;
    logic [15:0] rt;
    logic [3:0] rp;
    logic [31:0] rw;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      rt = 16'($urandom);
      rp = 4'($urandom);
      rw = $urandom;
      live_id(t);
      if ($urandom_range(0, 9) == 0) t = 16'($urandom);
      else if ($urandom_range(0, 5) == 0) t = 0;
      if (r < 30) send_request(MODE_TICK, rt, rp, rw);
      else if (r < 45) send_request(MODE_START, rt, rp, rw);
      else if (r < 55) send_request(MODE_KILL, t, rp, rw);
      else if (r < 75) send_request(MODE_QUEUE, t, rp, rw);
      else if (r < 93) send_request(MODE_PULL, rt, rp, rw);
      else if (r < 97) send_request(MODE_ENABLE, rt, rp, rw);
      else send_request(3'($urandom_range(6, 7)), rt, rp, rw);
    end
  endtask

  initial begin : stim
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_request(MODE_TICK, 0, 0, 0);
    send_request(MODE_PULL, 0, 0, 0);
    send_request(MODE_KILL, 0, 0, 0);
    send_request(MODE_QUEUE, 0, 0, 32'hFFFFFFFF);
    send_request(MODE_START, 16'hFFFF, 4'hF, 0);
    send_request(MODE_ENABLE, 0, 0, 0);
    send_request(MODE_ENABLE, 0, 0, 0);
    send_request(MODE_QUEUE, 0, 0, 32'hA5A5A5A5);
    send_request(MODE_PULL, 0, 0, 0);
    send_request(MODE_PULL, 0, 0, 0);
    for (int i = 0; i < 9; i++) send_request(MODE_QUEUE, 1, 0, 32'(i));
    send_request(MODE_TICK, 0, 0, 0);
    for (int i = 0; i < 16; i++) send_request(MODE_START, 0, 4'(i), 0);
    send_request(MODE_KILL, 16'hFFFF, 0, 0);
    send_request(MODE_KILL, 0, 0, 0);
    send_request(3'd6, 0, 0, 0);
    send_request(3'd7, 16'hFFFF, 4'hF, 32'hFFFFFFFF);
    wait_drain();
    random_phase(400);
    wait_drain();
    write_reg(CFG_TICK_QUANTUM, 16'd1000);
    write_reg(CFG_BASE_SLICE, 16'd65535);
    write_reg(CFG_PRIORITY_SLICE, 16'd0);
    random_phase(400);
    wait_drain();
    write_reg(CFG_TICK_QUANTUM, 16'd1);
    write_reg(CFG_BASE_SLICE, 16'd1);
    write_reg(CFG_PRIORITY_SLICE, 16'd65535);
    drain_stalls = 0;
    random_phase(400);
    wait_drain();
    drain_stalls = 1;
    write_reg(CFG_TICK_QUANTUM, 16'($urandom_range(1, 1000)));
    write_reg(CFG_BASE_SLICE, 16'($urandom_range(1, 65535)));
    write_reg(CFG_PRIORITY_SLICE, 16'($urandom));
    random_phase(410);
    wait_drain();
    $display("Sent %0d requests and checked %0d results over four register settings.",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
